FILE: src/cest_pkg.sv
// Package for the contact enter/stay/exit tracker.
// Holds the table size, operation and event codes, the FSM state type and the
// command struct shared by the top level, the row and its cells, and the row status struct.
package cest_pkg;

  localparam int unsigned TABLE_CAPACITY = 32;
  localparam int unsigned RESULT_LIMIT   = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned PAY_W          = 32;
  localparam int unsigned CNT_W          = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_CONTACT = 2'd1,
    OP_SWEEP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_STAY  = 2'd1,
    KIND_EXIT  = 2'd2,
    KIND_DROP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAY,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic mark_stale;
    logic contact;
    logic any_hit;
    logic sweep_start;
    logic sweep_adv;
    logic sweep_take;
  } cell_cmd_t;

  typedef struct packed {
    logic any_hit;
    logic full;
    logic tok_last;
    logic tok_exit;
  } row_status_t;

endpackage

FILE: src/cest_cell.sv
// One table slot of the tracker: valid and stale marks, key, payload and the
// sweep token. Depends on cest_pkg; instantiated in a chain by cest_row.
module cest_cell
  import cest_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [PAY_W-1:0] payload_i,
  input  logic             free_i,
  input  logic             tok_i,
  output logic             free_o,
  output logic             hit_o,
  output logic             tok_o,
  output logic             exit_o,
  output logic [KEY_W-1:0] key_o,
  output logic [PAY_W-1:0] payload_o
);

  logic             valid_q, valid_d;
  logic             stale_q, stale_d;
  logic             tok_q, tok_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] payload_q, payload_d;
  logic             claim;

  assign hit_o     = valid_q && (key_q == key_i);
  assign free_o    = free_i || !valid_q;
  assign claim     = cmd_i.contact && !cmd_i.any_hit && !valid_q && !free_i;
  assign tok_o     = tok_q;
  assign exit_o    = valid_q && stale_q;
  assign key_o     = key_q;
  assign payload_o = payload_q;

  always_comb begin
    valid_d   = valid_q;
    stale_d   = stale_q;
    tok_d     = tok_q;
    key_d     = key_q;
    payload_d = payload_q;
    if (cmd_i.mark_stale && valid_q) begin
      stale_d = 1'b1;
    end
    if (cmd_i.contact && hit_o) begin
      payload_d = payload_i;
      stale_d   = 1'b0;
    end
    if (claim) begin
      valid_d   = 1'b1;
      stale_d   = 1'b0;
      key_d     = key_i;
      payload_d = payload_i;
    end
    if (cmd_i.sweep_take && tok_q) begin
      valid_d = 1'b0;
      stale_d = 1'b0;
    end
    if (cmd_i.sweep_start || cmd_i.sweep_adv) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stale_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      stale_q <= stale_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

endmodule

FILE: src/cest_row.sv
// Row of table cells chained by the free-slot and sweep-token signals,
// with the hit reduction and the token-cell read mux.
// Depends on cest_pkg and cest_cell.
module cest_row
  import cest_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [PAY_W-1:0] payload_i,
  output row_status_t      status_o,
  output logic [KEY_W-1:0] tok_key_o,
  output logic [PAY_W-1:0] tok_payload_o
);

  logic [TABLE_CAPACITY-1:0] free_in, free_out, hit, tok_in, tok, ext;
  logic [KEY_W-1:0]          cell_key [TABLE_CAPACITY];
  logic [PAY_W-1:0]          cell_pay [TABLE_CAPACITY];

  for (genvar i = 0; i < TABLE_CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign free_in[i] = 1'b0;
      assign tok_in[i]  = cmd_i.sweep_start;
    end else begin : g_next
      assign free_in[i] = free_out[i-1];
      assign tok_in[i]  = tok[i-1] && !cmd_i.sweep_start;
    end
    cest_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .key_i     (key_i),
      .payload_i (payload_i),
      .free_i    (free_in[i]),
      .tok_i     (tok_in[i]),
      .free_o    (free_out[i]),
      .hit_o     (hit[i]),
      .tok_o     (tok[i]),
      .exit_o    (ext[i]),
      .key_o     (cell_key[i]),
      .payload_o (cell_pay[i])
    );
  end

  always_comb begin
    tok_key_o     = '0;
    tok_payload_o = '0;
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      if (tok[i]) begin
        tok_key_o     = tok_key_o | cell_key[i];
        tok_payload_o = tok_payload_o | cell_pay[i];
      end
    end
  end

  assign status_o.any_hit  = |hit;
  assign status_o.full     = !free_out[TABLE_CAPACITY-1];
  assign status_o.tok_last = tok[TABLE_CAPACITY-1];
  assign status_o.tok_exit = |(tok & ext);

`ifndef SYNTHESIS
  a_tok_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one sweep token in the row");
`endif

endmodule

FILE: src/contact_enter_stay_exit_tracker.sv
// Contact enter/stay/exit tracker, top level.
// Input channel s_axis: tuser carries the operation (frame start, contact
// report, frame end sweep); tdata carries the pair key and payload.
// Output channel m_axis: tuser carries the event kind (enter, stay, exit,
// dropped), tdata the key and payload, tlast marks the last result of an item.
// A frame start marks all valid slots stale and gives no result.
// A contact report is looked up against all slots at once; a
// known key gives a stay result, a new key an enter then a stay result,
// and a full table a dropped result.
// A frame end passes a token along the row of slots, one slot per cycle
// unless the output stalls, and gives one exit result per stale slot in slot
// order, at most RESULT_LIMIT per sweep.
// Results are registered: a contact report's first result appears the cycle
// after the transfer; exit results first wait in a pending register. A new item is
// taken once the previous one has given all of its results and the output register is free or being emptied.
// When the receiver stalls, the output holds and the sweep pauses.
// Reset clears all valid and stale marks, so the table starts empty.
// Depends on cest_pkg, cest_row and cest_cell.
module contact_enter_stay_exit_tracker
  import cest_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // pair_key[63:0], pair_payload[95:64]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // event_key[63:0], event_payload[95:64]
  output logic [1:0]  m_axis_tuser,  // event_kind[1:0]
  output logic        m_axis_tlast
);

  state_e           state_q, state_d;
  logic             o_valid_q, o_valid_d;
  logic [1:0]       o_kind_q, o_kind_d;
  logic [KEY_W-1:0] o_key_q, o_key_d;
  logic [PAY_W-1:0] o_pay_q, o_pay_d;
  logic             o_last_q, o_last_d;
  logic             pend_valid_q, pend_valid_d;
  logic [KEY_W-1:0] pend_key_q, pend_key_d;
  logic [PAY_W-1:0] pend_pay_q, pend_pay_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             out_free, accept;
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_pay;
  cell_cmd_t        cmd;
  row_status_t      status;
  logic [KEY_W-1:0] tok_key;
  logic [PAY_W-1:0] tok_pay;

  assign in_key        = s_axis_tdata[KEY_W-1:0];
  assign in_pay        = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
  assign out_free      = !o_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cest_row u_row (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .key_i         (in_key),
    .payload_i     (in_pay),
    .status_o      (status),
    .tok_key_o     (tok_key),
    .tok_payload_o (tok_pay)
  );

  always_comb begin
    state_d      = state_q;
    o_valid_d    = o_valid_q && !m_axis_tready;
    o_kind_d     = o_kind_q;
    o_key_d      = o_key_q;
    o_pay_d      = o_pay_q;
    o_last_d     = o_last_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_pay_d   = pend_pay_q;
    count_d      = count_q;
    cmd          = '0;
    cmd.any_hit  = status.any_hit;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            OP_START: begin
              cmd.mark_stale = 1'b1;
            end
            OP_CONTACT: begin
              cmd.contact = 1'b1;
              o_valid_d   = 1'b1;
              o_key_d     = in_key;
              o_pay_d     = in_pay;
              o_last_d    = 1'b1;
              if (status.any_hit) begin
                o_kind_d = KIND_STAY;
              end else if (status.full) begin
                o_kind_d = KIND_DROP;
              end else begin
                o_kind_d   = KIND_ENTER;
                o_last_d   = 1'b0;
                pend_key_d = in_key;
                pend_pay_d = in_pay;
                state_d    = ST_STAY;
              end
            end
            OP_SWEEP: begin
              cmd.sweep_start = 1'b1;
              pend_valid_d    = 1'b0;
              count_d         = '0;
              state_d         = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STAY: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_kind_d  = KIND_STAY;
          o_key_d   = pend_key_q;
          o_pay_d   = pend_pay_q;
          o_last_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (count_q == CNT_W'(RESULT_LIMIT)) begin
          state_d = ST_FLUSH;
        end else if (status.tok_exit) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              o_valid_d = 1'b1;
              o_kind_d  = KIND_EXIT;
              o_key_d   = pend_key_q;
              o_pay_d   = pend_pay_q;
              o_last_d  = 1'b0;
            end
            pend_valid_d   = 1'b1;
            pend_key_d     = tok_key;
            pend_pay_d     = tok_pay;
            count_d        = count_q + 1'b1;
            cmd.sweep_take = 1'b1;
            cmd.sweep_adv  = 1'b1;
            if (status.tok_last) begin
              state_d = ST_FLUSH;
            end
          end
        end else begin
          cmd.sweep_adv = 1'b1;
          if (status.tok_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          o_valid_d    = 1'b1;
          o_kind_d     = KIND_EXIT;
          o_key_d      = pend_key_q;
          o_pay_d      = pend_pay_q;
          o_last_d     = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      o_valid_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else begin
      state_q      <= state_d;
      o_valid_q    <= o_valid_d;
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_kind_q   <= o_kind_d;
    o_key_q    <= o_key_d;
    o_pay_q    <= o_pay_d;
    o_last_q   <= o_last_d;
    pend_key_q <= pend_key_d;
    pend_pay_q <= pend_pay_d;
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = {o_pay_q, o_key_q};
  assign m_axis_tlast  = o_last_q;

`ifndef SYNTHESIS
  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending exit left behind after a sweep");
  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RESULT_LIMIT))
    else $error("exit count beyond the result limit");
  a_enter_then_stay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_kind_q == KIND_ENTER) |-> (state_q == ST_STAY))
    else $error("enter result shown without a stay result to follow");
`endif

endmodule

FILE: sim/contact_enter_stay_exit_tracker_tb.sv
// Self-checking testbench for the contact enter/stay/exit tracker.
// Holds a table predictor with a queue of expected events and the stream drivers;
// depends on cest_pkg and contact_enter_stay_exit_tracker.
import cest_pkg::*;

typedef struct packed {
  kind_e       kind;
  logic [63:0] key;
  logic [31:0] payload;
  logic        last;
} tracker_event_t;

class contact_table_predictor;
  bit             slot_valid[TABLE_CAPACITY];
  bit             slot_stale[TABLE_CAPACITY];
  logic [63:0]    slot_key[TABLE_CAPACITY];
  logic [31:0]    slot_payload[TABLE_CAPACITY];
  tracker_event_t pending_events[$];
  int             errors;

  function void push_event(kind_e kind, logic [63:0] key, logic [31:0] payload, logic last);
    tracker_event_t ev;
    ev.kind    = kind;
    ev.key     = key;
    ev.payload = payload;
    ev.last    = last;
    pending_events = {pending_events, ev};
  endfunction

  function void note_item(logic [1:0] op, logic [63:0] key, logic [31:0] payload);
    int hit;
    int free_slot;
    int exits;
    hit       = -1;
    free_slot = -1;
    exits     = 0;
    case (op)
      OP_START: begin
        for (int i = 0; i < TABLE_CAPACITY; i++)
          if (slot_valid[i]) slot_stale[i] = 1'b1;
      end
      OP_CONTACT: begin
        for (int i = 0; i < TABLE_CAPACITY; i++) begin
          if (slot_valid[i]) begin
            if (hit < 0 && slot_key[i] == key) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          slot_payload[hit] = payload;
          slot_stale[hit]   = 1'b0;
          push_event(KIND_STAY, key, payload, 1'b1);
        end else if (free_slot < 0) begin
          push_event(KIND_DROP, key, payload, 1'b1);
        end else begin
          slot_valid[free_slot]   = 1'b1;
          slot_stale[free_slot]   = 1'b0;
          slot_key[free_slot]     = key;
          slot_payload[free_slot] = payload;
          push_event(KIND_ENTER, key, payload, 1'b0);
          push_event(KIND_STAY, key, payload, 1'b1);
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < TABLE_CAPACITY && exits < RESULT_LIMIT; i++) begin
          if (slot_valid[i] && slot_stale[i]) begin
            push_event(KIND_EXIT, slot_key[i], slot_payload[i], 1'b0);
            exits++;
            slot_valid[i] = 1'b0;
            slot_stale[i] = 1'b0;
          end
        end
        if (exits > 0) pending_events[pending_events.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    errors++;
    $display("mismatch %0d: %s", errors, what);
  endtask

  task check_event(logic [1:0] kind, logic [63:0] key, logic [31:0] payload, logic last);
    tracker_event_t want;
    if (pending_events.size() == 0) begin
      report($sformatf("unexpected event kind %0d key %h", kind, key));
      return;
    end
    want = pending_events.pop_front();
    if (kind !== want.kind)
      report($sformatf("kind %0d, expected %0d (key %h)", kind, want.kind, want.key));
    if (key !== want.key)
      report($sformatf("key %h, expected %h", key, want.key));
    if (payload !== want.payload)
      report($sformatf("payload %h, expected %h (key %h)", payload, want.payload, want.key));
    if (last !== want.last)
      report($sformatf("tlast %b, expected %b (key %h)", last, want.last, want.key));
  endtask
endclass

module contact_enter_stay_exit_tracker_tb;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         RANDOM_ITEMS = 410;
  localparam int         HOLD_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  contact_table_predictor sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          items_sent    = 0;
  int          items_taken   = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  int          cycle_count   = 0;
  logic [63:0] key_pool[$];

  contact_enter_stay_exit_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Once the input side is well under way, the receiver holds off long enough
  // for the block to fill up and refuse further transfers.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && items_taken >= 60) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64]);
        items_taken <= items_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tlast);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                           input logic [31:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {payload, key};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_contact();
    logic [63:0] key;
    int          pick;
    pick = $urandom_range(99);
    if (key_pool.size() != 0 && pick < 55) begin
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      if (pick >= 97) key = '1;
      else if (pick >= 94) key = '0;
      else key = {$urandom, $urandom};
      key_pool = {key_pool, key};
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    send_item(OP_CONTACT, key, $urandom);
  endtask

  task automatic run_frame();
    int count;
    if ($urandom_range(99) < 85) send_item(OP_START, {$urandom, $urandom}, $urandom);
    count = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (count) begin
      if ($urandom_range(19) == 0) send_item(OP_UNUSED, {$urandom, $urandom}, $urandom);
      send_contact();
    end
    if ($urandom_range(99) < 90) send_item(OP_SWEEP, {$urandom, $urandom}, $urandom);
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_START;
    send_idle_pct = 19;
    recv_idle_pct = 51;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty sweep and frame start on an empty table, extreme keys and
    // payloads, a duplicate in one frame and the unused operation.
    send_item(OP_SWEEP, '1, '1);
    send_item(OP_START, '1, '1);
    send_item(OP_CONTACT, '0, '0);
    send_item(OP_CONTACT, '1, '1);
    send_item(OP_CONTACT, '0, 32'h5555_aaaa);
    send_item(OP_UNUSED, 64'h0123_4567_89ab_cdef, 32'hdead_beef);
    send_item(OP_SWEEP, '0, '0);
    send_item(OP_START, '0, '0);
    send_item(OP_CONTACT, '1, 32'haaaa_5555);
    send_item(OP_SWEEP, '0, '0);
    send_item(OP_START, '0, '0);
    send_item(OP_SWEEP, '0, '0);

    // Fill every slot, overflow it, refresh a known key, then sweep the lot.
    for (int i = 0; i < TABLE_CAPACITY; i++)
      send_item(OP_CONTACT, {32'hc0de_0000 | i, ~i}, ~i);
    send_item(OP_CONTACT, 64'hffff_0000_ffff_0000, 32'h1234_5678);
    send_item(OP_CONTACT, {32'hc0de_0005, ~32'd5}, 32'h0f0f_0f0f);
    send_item(OP_START, '0, '0);
    send_item(OP_SWEEP, '0, '0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 51;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_frame();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (2 * TABLE_CAPACITY + 8) @(posedge clk_i);
    if (sb.pending_events.size() != 0)
      sb.report($sformatf("%0d expected events never arrived", sb.pending_events.size()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cest_pkg.sv
src/cest_cell.sv
src/cest_row.sv
src/contact_enter_stay_exit_tracker.sv
sim/contact_enter_stay_exit_tracker_tb.sv
